FILE: sv/drde_pkg.sv
// ----------------------------------------------------------------------------
// drde_pkg
// Shared types, constants and helpers of the dual route diffusing engine:
// event and message codes, the active/passive machine, the command and
// status bundles between controller and datapath, and saturating addition.
// ----------------------------------------------------------------------------
package drde_pkg;

  localparam int NEIGHBORS  = 16;
  localparam int NB_W       = 4;
  localparam int DIST_W     = 32;
  localparam int HOP_W      = 5;
  localparam int PEND_DEPTH = 4;
  localparam int PEND_W     = 2;
  localparam int PCNT_W     = 3;

  localparam logic [DIST_W-1:0] DIST_INF = '1;
  localparam logic [HOP_W-1:0]  SELF_IDX = HOP_W'(NEIGHBORS);

  // Event codes on the input beat
  localparam logic [2:0] OP_LINK_UP   = 3'd0;
  localparam logic [2:0] OP_LINK_DOWN = 3'd1;
  localparam logic [2:0] OP_UPDATE    = 3'd2;
  localparam logic [2:0] OP_QUERY     = 3'd3;
  localparam logic [2:0] OP_REPLY     = 3'd4;

  // Kinds of result beat
  localparam logic [1:0] K_UPDATE = 2'd0;
  localparam logic [1:0] K_QUERY  = 2'd1;
  localparam logic [1:0] K_REPLY  = 2'd2;
  localparam logic [1:0] K_STATUS = 2'd3;

  // Events driving the active/passive machine
  typedef enum logic [1:0] {
    EV_OTHERS,
    EV_QFS,
    EV_INC,
    EV_LAST
  } ev_t;

  typedef enum logic [2:0] {
    MS_PASSIVE,
    MS_ACTIVE0,
    MS_ACTIVE1,
    MS_ACTIVE2,
    MS_ACTIVE3
  } mstate_t;

  // Datapath commands
  typedef enum logic [4:0] {
    C_NONE,
    C_CAPTURE,
    C_APPLY,
    C_OP1_ACT,
    C_OP2_ACT,
    C_OP3_ACT,
    C_MIN_INIT,
    C_MIN_STEP,
    C_AFF,
    C_FEAS_STEP,
    C_LOCAL,
    C_DIFF_SET,
    C_QUERY_STEP,
    C_FSM_EV,
    C_SV_CHK,
    C_DR_CLEAR,
    C_DR_LAST,
    C_DR_SET,
    C_FLOOD_STEP,
    C_POP,
    C_SR_CHK,
    C_EMIT_UPD,
    C_OWE,
    C_STATUS
  } cmd_t;

  // Which neighbor the table read port looks at
  typedef enum logic [1:0] {
    RS_N,
    RS_IDX,
    RS_SUCC,
    RS_DST
  } rsel_t;

  // Controller states
  typedef enum logic [4:0] {
    CS_IDLE,
    CS_APPLY,
    CS_OP1,
    CS_OP2,
    CS_OP3,
    CS_T_START,
    CS_MIN_T,
    CS_T_AFF,
    CS_FEAS,
    CS_T_FD,
    CS_DIFF,
    CS_QSCAN,
    CS_T_OK,
    CS_T_SV,
    CS_DR_CHK,
    CS_DR_ANY,
    CS_MIN_D,
    CS_DR_SET,
    CS_FLOOD,
    CS_SR_POP,
    CS_SR_CHK,
    CS_FINISH,
    CS_EMIT_UPD,
    CS_OWE,
    CS_STATUS
  } cstate_t;

  typedef struct packed {
    cmd_t  cmd;
    rsel_t rd;
  } ctl_t;

  typedef struct packed {
    logic [2:0] op;
    logic       passive;
    logic       known_a;
    logic       await_a;
    logic       owe_a;
    logic       up_a;
    logic       any_known;
    logic       any_await;
    logic       self_succ;
    logic       affected;
    logic       hit;
    logic       dmin_eq_own;
    logic       min_eq_own;
    logic       pcnt_zero;
    logic       ev_qfs;
    logic       scan_end;
    logic       out_free;
  } sts_t;

  // Saturating distance sum, infinity absorbs
  function automatic logic [DIST_W-1:0] dadd(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == DIST_INF || b == DIST_INF || s >= {1'b0, DIST_INF}) begin
      return DIST_INF;
    end
    return s[DIST_W-1:0];
  endfunction

  // Active/passive transition; fc is the feasibility flag
  function automatic mstate_t fsm_next(mstate_t s, ev_t ev, logic fc);
    mstate_t r;
    r = s;
    unique case (s)
      MS_PASSIVE: if (!fc) r = (ev == EV_QFS) ? MS_ACTIVE3 : MS_ACTIVE1;
      MS_ACTIVE0: if (ev == EV_LAST) r = fc ? MS_PASSIVE : MS_ACTIVE2;
      MS_ACTIVE1: begin
        if (ev == EV_INC) r = MS_ACTIVE0;
        else if (ev == EV_LAST) r = MS_PASSIVE;
        else if (ev == EV_QFS) r = MS_ACTIVE2;
      end
      MS_ACTIVE2: if (ev == EV_LAST) r = fc ? MS_PASSIVE : MS_ACTIVE3;
      MS_ACTIVE3: begin
        if (ev == EV_LAST) r = MS_PASSIVE;
        else if (ev == EV_INC) r = MS_ACTIVE2;
      end
      default: r = s;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/drde_ctrl.sv
// ----------------------------------------------------------------------------
// drde_ctrl
// Sequencer of the engine: walks each event through table updates, the
// neighbor scans, the reply stack and the result beats.
// ----------------------------------------------------------------------------
module drde_ctrl import drde_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t st,
  output ctl_t ctl
);

  cstate_t st_r, st_nxt;
  cstate_t ret_r, ret_nxt;
  logic    rpl_r, rpl_nxt;
  logic    need;

  assign need = (st.op == OP_QUERY);

  // Hold state, return point and flood follow-up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= CS_IDLE;
      ret_r <= CS_FINISH;
      rpl_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      ret_r <= ret_nxt;
      rpl_r <= rpl_nxt;
    end
  end

  // Next state
  always_comb begin
    st_nxt  = st_r;
    ret_nxt = ret_r;
    rpl_nxt = rpl_r;
    unique case (st_r)
      CS_IDLE: if (in_tvalid) st_nxt = CS_APPLY;
      CS_APPLY: begin
        priority if (st.op == OP_LINK_UP) begin
          st_nxt = st.passive ? CS_T_START : CS_DR_CHK;
        end else if (st.op == OP_LINK_DOWN) begin
          st_nxt = st.passive ? CS_T_START : CS_OP1;
        end else if (st.op == OP_UPDATE) begin
          if (!st.known_a) st_nxt = CS_STATUS;
          else st_nxt = st.passive ? CS_T_START : CS_OP2;
        end else if (st.op == OP_QUERY) begin
          st_nxt = st.passive ? CS_T_START : CS_OP3;
        end else if (st.op == OP_REPLY) begin
          st_nxt = CS_DR_CHK;
        end else begin
          st_nxt = CS_STATUS;
        end
      end
      CS_OP1: st_nxt = CS_DR_CHK;
      CS_OP2: st_nxt = CS_STATUS;
      CS_OP3: begin
        st_nxt  = CS_SR_POP;
        ret_nxt = CS_FINISH;
      end
      CS_T_START: begin
        if (!st.any_known || st.self_succ) begin
          st_nxt  = need ? CS_SR_POP : CS_FINISH;
          ret_nxt = CS_FINISH;
        end else begin
          st_nxt = CS_MIN_T;
        end
      end
      CS_MIN_T: if (st.scan_end) st_nxt = CS_T_AFF;
      CS_T_AFF: begin
        if (st.affected) begin
          st_nxt = CS_FEAS;
        end else begin
          st_nxt  = need ? CS_SR_POP : CS_FINISH;
          ret_nxt = CS_FINISH;
        end
      end
      CS_FEAS: if (st.scan_end) st_nxt = CS_T_FD;
      CS_T_FD: begin
        if (st.hit) begin
          if (st.dmin_eq_own) begin
            st_nxt  = need ? CS_SR_POP : CS_FINISH;
            ret_nxt = CS_FINISH;
          end else begin
            st_nxt  = CS_FLOOD;
            rpl_nxt = need;
          end
        end else if (need && !st.ev_qfs) begin
          st_nxt  = CS_SR_POP;
          ret_nxt = CS_DIFF;
        end else begin
          st_nxt = CS_DIFF;
        end
      end
      CS_DIFF:  st_nxt = CS_QSCAN;
      CS_QSCAN: if (st.scan_end) st_nxt = CS_T_OK;
      CS_T_OK:  st_nxt = CS_T_SV;
      CS_T_SV:  st_nxt = CS_FINISH;
      CS_DR_CHK: st_nxt = st.await_a ? CS_DR_ANY : CS_FINISH;
      CS_DR_ANY: st_nxt = st.any_await ? CS_FINISH : CS_MIN_D;
      CS_MIN_D: if (st.scan_end) st_nxt = CS_DR_SET;
      CS_DR_SET: begin
        if (st.min_eq_own) begin
          st_nxt  = CS_SR_POP;
          ret_nxt = CS_FINISH;
        end else begin
          st_nxt  = CS_FLOOD;
          rpl_nxt = 1'b1;
        end
      end
      CS_FLOOD: begin
        if (st.scan_end) begin
          st_nxt  = rpl_r ? CS_SR_POP : CS_FINISH;
          ret_nxt = CS_FINISH;
        end
      end
      CS_SR_POP: st_nxt = st.pcnt_zero ? ret_r : CS_SR_CHK;
      CS_SR_CHK: if (!st.up_a || st.out_free) st_nxt = ret_r;
      CS_FINISH: st_nxt = (st.op == OP_LINK_UP) ? CS_EMIT_UPD : CS_STATUS;
      CS_EMIT_UPD: if (st.out_free) st_nxt = CS_OWE;
      CS_OWE: if (!st.owe_a || st.out_free) st_nxt = CS_STATUS;
      CS_STATUS: if (st.out_free) st_nxt = CS_IDLE;
      default: st_nxt = CS_IDLE;
    endcase
  end

  // Commands per state
  always_comb begin
    in_tready = 1'b0;
    ctl.cmd   = C_NONE;
    ctl.rd    = RS_N;
    unique case (st_r)
      CS_IDLE: begin
        in_tready = 1'b1;
        ctl.cmd   = C_CAPTURE;
      end
      CS_APPLY:    ctl.cmd = C_APPLY;
      CS_OP1:      ctl.cmd = C_OP1_ACT;
      CS_OP2:      ctl.cmd = C_OP2_ACT;
      CS_OP3:      ctl.cmd = C_OP3_ACT;
      CS_T_START:  ctl.cmd = C_MIN_INIT;
      CS_MIN_T: begin
        ctl.cmd = C_MIN_STEP;
        ctl.rd  = RS_IDX;
      end
      CS_T_AFF: begin
        ctl.cmd = C_AFF;
        ctl.rd  = RS_SUCC;
      end
      CS_FEAS: begin
        ctl.cmd = C_FEAS_STEP;
        ctl.rd  = RS_IDX;
      end
      CS_T_FD:     ctl.cmd = C_LOCAL;
      CS_DIFF: begin
        ctl.cmd = C_DIFF_SET;
        ctl.rd  = RS_SUCC;
      end
      CS_QSCAN: begin
        ctl.cmd = C_QUERY_STEP;
        ctl.rd  = RS_IDX;
      end
      CS_T_OK:     ctl.cmd = C_FSM_EV;
      CS_T_SV: begin
        ctl.cmd = C_SV_CHK;
        ctl.rd  = RS_SUCC;
      end
      CS_DR_CHK:   ctl.cmd = C_DR_CLEAR;
      CS_DR_ANY:   ctl.cmd = C_DR_LAST;
      CS_MIN_D: begin
        ctl.cmd = C_MIN_STEP;
        ctl.rd  = RS_IDX;
      end
      CS_DR_SET:   ctl.cmd = C_DR_SET;
      CS_FLOOD: begin
        ctl.cmd = C_FLOOD_STEP;
        ctl.rd  = RS_IDX;
      end
      CS_SR_POP:   ctl.cmd = C_POP;
      CS_SR_CHK: begin
        ctl.cmd = C_SR_CHK;
        ctl.rd  = RS_DST;
      end
      CS_FINISH:   ctl.cmd = C_NONE;
      CS_EMIT_UPD: ctl.cmd = C_EMIT_UPD;
      CS_OWE:      ctl.cmd = C_OWE;
      CS_STATUS:   ctl.cmd = C_STATUS;
      default:     ctl.cmd = C_NONE;
    endcase
  end

endmodule

FILE: sv/drde_dp.sv
// ----------------------------------------------------------------------------
// drde_dp
// Datapath: neighbor tables, route registers, reply stack, scan unit with
// one saturating adder, and the output register.
// ----------------------------------------------------------------------------
module drde_dp import drde_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl,
  output sts_t              st,
  input  logic [2:0]        ev_op,
  input  logic [NB_W-1:0]   ev_nb,
  input  logic [DIST_W-1:0] ev_dist,
  input  logic              cfg_wr,
  input  logic              cfg_root,
  output logic              root,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [NB_W-1:0]   out_dst,
  output logic [DIST_W-1:0] out_dist,
  output logic              out_last,
  output logic [2:0]        out_fsm,
  output logic              out_hv,
  output logic [HOP_W-1:0]  out_hi,
  output logic              out_rv
);

  logic [DIST_W-1:0]  cost_r [NEIGHBORS];
  logic [DIST_W-1:0]  peer_r [NEIGHBORS];
  logic [NEIGHBORS-1:0] known_r, await_r, owe_r;
  logic [NB_W-1:0]    pend_r [PEND_DEPTH];
  logic [PCNT_W-1:0]  pcnt_r;
  logic [DIST_W-1:0]  route_r, own_r, fd_r, min_r;
  logic [HOP_W-1:0]   succ_r;
  logic               sv_r, root_r, found_r, hit_r, ok_r;
  mstate_t            ms_r;
  ev_t                ev_r;
  logic [2:0]         op_r;
  logic [NB_W-1:0]    n_r, idx_r, nh_r, dst_r;
  logic [DIST_W-1:0]  dist_r;

  logic [NB_W-1:0]    rd_a;
  logic [DIST_W-1:0]  cost_a, peer_a, sum_a, dmin_t, diff_d;
  logic               up_a, succ_is_n, step, adv, out_free;
  logic               emit_en;
  logic [1:0]         emit_kind;
  logic [NB_W-1:0]    emit_dst;

  logic               out_valid_r, out_last_r, out_hv_r, out_rv_r;
  logic [1:0]         out_kind_r;
  logic [NB_W-1:0]    out_dst_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic [2:0]         out_fsm_r;
  logic [HOP_W-1:0]   out_hi_r;

  // Table read port
  always_comb begin
    unique case (ctl.rd)
      RS_N:    rd_a = n_r;
      RS_IDX:  rd_a = idx_r;
      RS_SUCC: rd_a = succ_r[NB_W-1:0];
      RS_DST:  rd_a = dst_r;
      default: rd_a = n_r;
    endcase
  end

  assign cost_a    = cost_r[rd_a];
  assign peer_a    = peer_r[rd_a];
  assign up_a      = (cost_a != DIST_INF);
  assign sum_a     = dadd(cost_a, peer_a);
  assign dmin_t    = root_r ? '0 : min_r;
  assign succ_is_n = sv_r && (succ_r == {1'b0, n_r});
  assign diff_d    = !sv_r ? DIST_INF : (succ_r[HOP_W-1] ? '0 : sum_a);
  assign out_free  = !out_valid_r || out_ready;

  // Scan index advance
  assign step = (ctl.cmd == C_MIN_STEP) || (ctl.cmd == C_FEAS_STEP) ||
                (ctl.cmd == C_FLOOD_STEP) || (ctl.cmd == C_QUERY_STEP);
  assign adv  = ((ctl.cmd == C_FLOOD_STEP) || (ctl.cmd == C_QUERY_STEP)) ?
                (!up_a || out_free) : 1'b1;

  // Status toward the controller
  always_comb begin
    st.op          = op_r;
    st.passive     = (ms_r == MS_PASSIVE);
    st.known_a     = known_r[rd_a];
    st.await_a     = await_r[rd_a];
    st.owe_a       = owe_r[rd_a];
    st.up_a        = up_a;
    st.any_known   = |known_r;
    st.any_await   = |await_r;
    st.self_succ   = sv_r && (succ_r == SELF_IDX);
    st.affected    = (route_r != dmin_t) ||
                     ((dmin_t != DIST_INF) &&
                      (!sv_r || succ_r[HOP_W-1] || (sum_a != dmin_t)));
    st.hit         = hit_r;
    st.dmin_eq_own = (dmin_t == own_r);
    st.min_eq_own  = (min_r == own_r);
    st.pcnt_zero   = (pcnt_r == '0);
    st.ev_qfs      = (ev_r == EV_QFS);
    st.scan_end    = step && adv && (idx_r == NB_W'(NEIGHBORS - 1));
    st.out_free    = out_free;
  end

  // Pick the beat to send
  always_comb begin
    emit_en   = 1'b0;
    emit_kind = K_UPDATE;
    emit_dst  = n_r;
    unique case (ctl.cmd)
      C_FLOOD_STEP: begin
        emit_en  = up_a && out_free;
        emit_dst = idx_r;
      end
      C_QUERY_STEP: begin
        emit_en   = up_a && out_free;
        emit_kind = K_QUERY;
        emit_dst  = idx_r;
      end
      C_SR_CHK: begin
        emit_en   = up_a && out_free;
        emit_kind = K_REPLY;
        emit_dst  = dst_r;
      end
      C_EMIT_UPD: emit_en = out_free;
      C_OWE: begin
        emit_en   = owe_r[rd_a] && out_free;
        emit_kind = K_REPLY;
      end
      C_STATUS: begin
        emit_en   = out_free;
        emit_kind = K_STATUS;
      end
      default: emit_en = 1'b0;
    endcase
  end

  // Tables, route and scan registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NEIGHBORS; i++) begin
        cost_r[i] <= DIST_INF;
        peer_r[i] <= DIST_INF;
      end
      known_r <= '0;
      await_r <= '0;
      owe_r   <= '0;
      pcnt_r  <= '0;
      route_r <= DIST_INF;
      own_r   <= DIST_INF;
      fd_r    <= DIST_INF;
      succ_r  <= SELF_IDX;
      sv_r    <= 1'b0;
      root_r  <= 1'b0;
      ms_r    <= MS_PASSIVE;
      ev_r    <= EV_OTHERS;
      idx_r   <= '0;
      found_r <= 1'b0;
      hit_r   <= 1'b0;
      ok_r    <= 1'b0;
      min_r   <= DIST_INF;
      op_r    <= OP_LINK_UP;
    end else begin
      // advance or park the scan index
      if (step) begin
        if (adv) idx_r <= idx_r + 1'b1;
      end else begin
        idx_r <= '0;
      end
      unique case (ctl.cmd)
        C_CAPTURE: begin
          op_r   <= ev_op;
          n_r    <= ev_nb;
          dist_r <= ev_dist;
        end
        C_APPLY: begin
          ev_r <= EV_OTHERS;
          priority if (op_r == OP_LINK_UP) begin
            if (succ_is_n) begin
              sv_r    <= 1'b0;
              route_r <= DIST_INF;
            end
            cost_r[n_r]  <= dist_r;
            known_r[n_r] <= 1'b1;
          end else if (op_r == OP_LINK_DOWN) begin
            ev_r         <= EV_INC;
            cost_r[n_r]  <= DIST_INF;
            known_r[n_r] <= 1'b1;
            peer_r[n_r]  <= DIST_INF;
          end else if (op_r == OP_UPDATE) begin
            peer_r[n_r] <= dist_r;
          end else if (op_r == OP_QUERY) begin
            ev_r        <= succ_is_n ? EV_QFS : EV_OTHERS;
            peer_r[n_r] <= dist_r;
            if (pcnt_r < PCNT_W'(PEND_DEPTH)) begin
              pend_r[pcnt_r[PEND_W-1:0]] <= n_r;
              pcnt_r <= pcnt_r + 1'b1;
            end
          end else begin
            ev_r <= EV_OTHERS;
          end
        end
        C_OP1_ACT: ms_r <= fsm_next(ms_r, EV_INC, 1'b0);
        C_OP2_ACT: begin
          if (succ_is_n) route_r <= sum_a;
          ms_r <= fsm_next(ms_r, EV_OTHERS, 1'b0);
        end
        C_OP3_ACT: begin
          if (ev_r == EV_QFS) route_r <= sum_a;
          ms_r <= fsm_next(ms_r, ev_r, 1'b0);
        end
        C_MIN_INIT: begin
          min_r   <= DIST_INF;
          found_r <= 1'b0;
        end
        C_MIN_STEP: begin
          if (sum_a < min_r) begin
            min_r   <= sum_a;
            nh_r    <= idx_r;
            found_r <= 1'b1;
          end
        end
        C_AFF: hit_r <= 1'b0;
        C_FEAS_STEP: begin
          if (!hit_r && up_a && (peer_a < fd_r) && (sum_a == dmin_t)) begin
            hit_r <= 1'b1;
            nh_r  <= idx_r;
          end
        end
        C_LOCAL: begin
          if (hit_r) begin
            route_r <= dmin_t;
            own_r   <= dmin_t;
            fd_r    <= dmin_t;
            succ_r  <= {1'b0, nh_r};
            sv_r    <= 1'b1;
          end
        end
        C_DIFF_SET: begin
          route_r <= diff_d;
          own_r   <= diff_d;
          fd_r    <= diff_d;
          ok_r    <= 1'b0;
        end
        C_QUERY_STEP: begin
          if (up_a && out_free) begin
            await_r[idx_r] <= 1'b1;
            ok_r           <= 1'b1;
          end
        end
        C_FSM_EV: if (ok_r) ms_r <= fsm_next(ms_r, ev_r, 1'b0);
        C_SV_CHK: if (sv_r && (succ_r[HOP_W-1] || !up_a)) sv_r <= 1'b0;
        C_DR_CLEAR: begin
          if (await_r[rd_a]) begin
            peer_r[n_r]  <= (op_r == OP_REPLY) ? dist_r : peer_a;
            await_r[n_r] <= 1'b0;
          end
        end
        C_DR_LAST: begin
          if (!(|await_r)) ms_r <= fsm_next(ms_r, EV_LAST, 1'b1);
          min_r   <= DIST_INF;
          found_r <= 1'b0;
        end
        C_DR_SET: begin
          route_r <= min_r;
          own_r   <= min_r;
          fd_r    <= min_r;
          sv_r    <= found_r;
          succ_r  <= found_r ? {1'b0, nh_r} : SELF_IDX;
        end
        C_POP: begin
          if (pcnt_r != '0) begin
            pcnt_r <= pcnt_r - 1'b1;
            dst_r  <= pend_r[PEND_W'(pcnt_r - 1'b1)];
          end
        end
        C_SR_CHK: if (!up_a) owe_r[dst_r] <= 1'b1;
        C_OWE:    if (owe_r[rd_a] && out_free) owe_r[n_r] <= 1'b0;
        default: ;
      endcase
      // reload the route for a new root setting
      if (cfg_wr) begin
        root_r  <= cfg_root;
        route_r <= cfg_root ? '0 : DIST_INF;
        own_r   <= cfg_root ? '0 : DIST_INF;
        fd_r    <= cfg_root ? '0 : DIST_INF;
        succ_r  <= SELF_IDX;
        sv_r    <= cfg_root;
      end
    end
  end

  // Output register: hold a beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      out_kind_r <= emit_kind;
      if (emit_kind == K_STATUS) begin
        out_dst_r  <= '0;
        out_dist_r <= route_r;
        out_last_r <= 1'b1;
        out_fsm_r  <= ms_r;
        out_hv_r   <= sv_r;
        out_hi_r   <= sv_r ? succ_r : '0;
        out_rv_r   <= (ms_r == MS_PASSIVE) && (route_r != DIST_INF) && sv_r;
      end else begin
        out_dst_r  <= emit_dst;
        out_dist_r <= own_r;
        out_last_r <= 1'b0;
        out_fsm_r  <= '0;
        out_hv_r   <= 1'b0;
        out_hi_r   <= '0;
        out_rv_r   <= 1'b0;
      end
    end
  end

  assign root      = root_r;
  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_dst   = out_dst_r;
  assign out_dist  = out_dist_r;
  assign out_last  = out_last_r;
  assign out_fsm   = out_fsm_r;
  assign out_hv    = out_hv_r;
  assign out_hi    = out_hi_r;
  assign out_rv    = out_rv_r;

endmodule

FILE: sv/dual_route_diffusing_engine_top.sv
// ----------------------------------------------------------------------------
// dual_route_diffusing_engine_top
// Diffusing-update route engine for one destination, stream in and out.
// ----------------------------------------------------------------------------
// One event is handled at a time, and the next one is accepted only after the
// status beat of the current one has been loaded. Some events need no neighbor
// walk; others run a minimum walk that may find the route unaffected. When the
// engine diffuses, each route recomputation walks all 16 neighbors through one
// shared saturating adder, once for the minimum and once for the feasibility
// search, and a flood or query walk visits all 16 neighbors again. Every
// message beat leaves through a single output register, so a stalled consumer
// stalls the walk. Each event ends with one status beat marked by tlast.
module dual_route_diffusing_engine_top import drde_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // neighbor[3:0], distance[35:4], zero[39:36]
  input  logic [2:0]  in_tuser,   // opcode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // dest_neighbor[3:0], msg_distance[35:4],
                                  // fsm_state[38:36], hop_valid[39],
                                  // hop_index[44:40], route_valid[45]
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [0:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  ctl_t              ctl;
  sts_t              st;
  logic              root, cfg_wr;
  logic [1:0]        o_kind;
  logic [NB_W-1:0]   o_dst;
  logic [DIST_W-1:0] o_dist;
  logic [2:0]        o_fsm;
  logic              o_hv, o_rv;
  logic [HOP_W-1:0]  o_hi;

  // Register write on the access beat
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == 1'b0);
  assign cfg_prdata = {31'b0, root};

  drde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .ctl       (ctl)
  );

  drde_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .st        (st),
    .ev_op     (in_tuser),
    .ev_nb     (in_tdata[3:0]),
    .ev_dist   (in_tdata[35:4]),
    .cfg_wr    (cfg_wr),
    .cfg_root  (cfg_pwdata[0]),
    .root      (root),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (o_kind),
    .out_dst   (o_dst),
    .out_dist  (o_dist),
    .out_last  (out_tlast),
    .out_fsm   (o_fsm),
    .out_hv    (o_hv),
    .out_hi    (o_hi),
    .out_rv    (o_rv)
  );

  // Pack the result beat
  assign out_tuser = o_kind;
  assign out_tdata = {2'b00, o_rv, o_hi, o_hv, o_fsm, o_dist, o_dst};

  // One event in flight: no new beat right after an accept
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an event is in flight");

  // Status beats close an event, message beats never do
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == K_STATUS)))
    else $error("tlast does not match status beat");

  // Message beats carry no route status
  a_msg_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != K_STATUS) |-> (out_tdata[45:36] == '0))
    else $error("status fields set on a message beat");

  // No chosen successor means zero hop index
  a_hop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == K_STATUS) && !out_tdata[39] |-> (out_tdata[44:40] == '0))
    else $error("hop index set without successor");

endmodule
